// ----- src/heating_bus_message_decoder_top_assert.svh -----
// assertion macros for the heating bus message decoder
`ifndef HEATING_BUS_MESSAGE_DECODER_TOP_ASSERT_SVH
`define HEATING_BUS_MESSAGE_DECODER_TOP_ASSERT_SVH
`ifndef SYNTH
`define HBD_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HBD_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HBD_ASSERT_IMPL(label, clk, rst, prop, msg)
`define HBD_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ----- src/hbd_pkg.sv -----
package hbd_pkg;

  localparam int MaxFrameBytes = 32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         message_kind;
    logic [3:0]         field_index;
    logic [1:0]         field_kind;
    logic signed [23:0] field_value;
    logic [1:0]         scale_code;
    logic [1:0]         status;
    logic               last_result;
  } out_item_t;

  localparam logic [1:0] FkNum  = 2'd0;
  localparam logic [1:0] FkFlag = 2'd1;
  localparam logic [1:0] FkCode = 2'd2;

  localparam logic [1:0] StField     = 2'd0;
  localparam logic [1:0] StLength    = 2'd1;
  localparam logic [1:0] StUnhandled = 2'd2;

  localparam logic [7:0] SrcBoiler  = 8'h08;
  localparam logic [7:0] SrcCtrl    = 8'h10;
  localparam logic [7:0] SrcSolar   = 8'h11;
  localparam logic [7:0] SrcMixer   = 8'h21;
  localparam logic [7:0] PollBit    = 8'h80;

  // message kinds as reported in message_kind
  typedef enum logic [3:0] {
    MkFast, MkSlow, MkHotWater, MkUnknown1, MkOutdoor,
    MkCircuit1, MkCircuit2, MkWm1, MkWm2, MkMixer
  } msg_kind_t;

  // type bytes per source
  localparam logic [7:0] TyUnknown1 = 8'h14;
  localparam logic [7:0] TyFast     = 8'h18;
  localparam logic [7:0] TySlow     = 8'h19;
  localparam logic [7:0] TyHotWater = 8'h34;
  localparam logic [7:0] TyCircuit1 = 8'h3E;
  localparam logic [7:0] TyCircuit2 = 8'h48;
  localparam logic [7:0] TyOutdoor  = 8'hA3;
  localparam logic [7:0] TyWm1      = 8'h9C;
  localparam logic [7:0] TyWm2      = 8'h1E;
  localparam logic [7:0] TyMixer    = 8'hAB;
  localparam logic [7:0] TyNop0     = 8'h06;
  localparam logic [7:0] TyNop1     = 8'h1A;
  localparam logic [7:0] TyNop2     = 8'h35;
  localparam logic [7:0] TyNop3     = 8'h9D;
  localparam logic [7:0] TyNop4     = 8'hAC;

  typedef enum logic [2:0] {
    S_RECV, S_DEC0, S_DEC1, S_CHECK, S_RD0, S_RD1, S_RD2, S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] off;
    logic [2:0] arg;
    logic [1:0] scale;
  } field_desc_t;

  // per-message info: field count and payload length
  typedef struct packed {
    logic [4:0] count;
    logic [4:0] len;
    logic       at_least;
  } msg_desc_t;

  function automatic msg_desc_t msg_desc(input logic [3:0] k);
    msg_desc_t d;
    d = '0;
    unique case (k)
      MkFast:     d = '{5'd16, 5'd26, 1'b0};
      MkSlow:     d = '{5'd7,  5'd26, 1'b0};
      MkHotWater: d = '{5'd12, 5'd17, 1'b0};
      MkUnknown1: d = '{5'd2,  5'd4,  1'b0};
      MkOutdoor:  d = '{5'd2,  5'd4,  1'b1};
      MkCircuit1: d = '{5'd15, 5'd16, 1'b0};
      MkCircuit2: d = '{5'd15, 5'd16, 1'b0};
      MkWm1:      d = '{5'd2,  5'd6,  1'b0};
      MkWm2:      d = '{5'd1,  5'd3,  1'b0};
      MkMixer:    d = '{5'd4,  5'd8,  1'b0};
      default: d = '0;
    endcase
    return d;
  endfunction

  function automatic field_desc_t fd(input int kd, input int o, input int a, input int s);
    field_desc_t f;
    f.kind = 2'(kd);
    f.off = 5'(o);
    f.arg = 3'(a);
    f.scale = 2'(s);
    return f;
  endfunction

  function automatic field_desc_t field_desc(input logic [3:0] m, input logic [3:0] i);
    field_desc_t f;
    f = '0;
    unique case (m)
      MkFast: begin
        case (i)
          4'd0: f = fd(0,1,1,0);   4'd1: f = fd(0,2,2,2);
          4'd2: f = fd(0,12,2,2);  4'd3: f = fd(0,14,2,2);
          4'd4: f = fd(0,4,1,0);   4'd5: f = fd(0,5,1,0);
          4'd6: f = fd(0,16,2,2);  4'd7: f = fd(0,18,1,2);
          4'd8: f = fd(2,19,2,0);  4'd9: f = fd(2,22,1,0);
          4'd10: f = fd(1,8,0,0);  4'd11: f = fd(1,8,2,0);
          4'd12: f = fd(1,8,3,0);  4'd13: f = fd(1,8,5,0);
          4'd14: f = fd(1,8,6,0);  default: f = fd(1,8,7,0);
        endcase
      end
      MkSlow: begin
        case (i)
          4'd0: f = fd(0,1,2,2);  4'd1: f = fd(0,3,2,2);
          4'd2: f = fd(0,5,2,2);  4'd3: f = fd(0,11,3,0);
          4'd4: f = fd(0,14,3,0); 4'd5: f = fd(0,20,3,0);
          default: f = fd(0,23,3,0);
        endcase
      end
      MkHotWater: begin
        case (i)
          4'd0: f = fd(0,1,1,0);  4'd1: f = fd(0,2,2,2);
          4'd2: f = fd(0,11,3,0); 4'd3: f = fd(0,14,3,0);
          4'd4: f = fd(0,4,2,2);  4'd5: f = fd(1,6,0,0);
          4'd6: f = fd(1,6,1,0);  4'd7: f = fd(1,6,2,0);
          4'd8: f = fd(1,6,3,0);  4'd9: f = fd(1,6,4,0);
          4'd10: f = fd(1,6,5,0); default: f = fd(1,8,2,0);
        endcase
      end
      MkUnknown1: f = (i == 4'd0) ? fd(0,0,2,0) : fd(0,2,2,0);
      MkOutdoor: f = (i == 4'd0) ? fd(0,1,1,0) : fd(1,3,0,0);
      MkCircuit1, MkCircuit2: begin
        case (i)
          4'd0: f = fd(0,3,1,1);  4'd1: f = fd(0,4,2,2);
          4'd2: f = fd(0,15,1,0); 4'd3: f = fd(1,1,2,0);
          4'd4: f = fd(1,1,0,0);  4'd5: f = fd(1,1,1,0);
          4'd6: f = fd(1,1,3,0);  4'd7: f = fd(1,1,4,0);
          4'd8: f = fd(1,1,5,0);  4'd9: f = fd(1,1,6,0);
          4'd10: f = fd(1,1,7,0); 4'd11: f = fd(1,2,0,0);
          4'd12: f = fd(1,2,1,0); 4'd13: f = fd(1,2,7,0);
          default: f = fd(1,14,4,0);
        endcase
      end
      MkWm1: f = (i == 4'd0) ? fd(0,1,2,2) : fd(1,3,2,0);
      MkWm2: f = fd(0,1,2,2);
      MkMixer: begin
        case (i)
          4'd0: f = fd(0,1,1,0); 4'd1: f = fd(0,2,2,2);
          4'd2: f = fd(0,5,1,0); default: f = fd(1,4,2,0);
        endcase
      end
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ----- src/hbd_ram.sv -----
module hbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/heating_bus_message_decoder_top.sv -----
// heating bus message decoder: takes one frame byte per item (source, dest,
// type, payload) into a byte ram; a byte that is not last is taken every
// cycle. after the last byte the frame is checked and decoded: polling and
// no-op frames are dropped, known messages emit one result item per field in
// table order, errors give one status item. the header is read back from the
// ram through S_DEC0, S_DEC1 and S_CHECK, and a status item is registered in
// S_CHECK. each field then reads 1 to 3 bytes, one at a time, through the
// single ram read port, and a result is held while the receiver stalls. no input
// is taken while a frame is being decoded or results are pending; bytes are
// taken again right after the last result of a frame is accepted.
`include "heating_bus_message_decoder_top_assert.svh"
module heating_bus_message_decoder_top #(
  parameter int MAX_FRAME_BYTES = hbd_pkg::MaxFrameBytes
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hbd_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output hbd_pkg::out_item_t out_item
);
  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam int CW = AW + 1;

  // classification outcome
  localparam logic [1:0] ClsKnown     = 2'd0;
  localparam logic [1:0] ClsNone      = 2'd1;
  localparam logic [1:0] ClsUnhandled = 2'd2;

  hbd_pkg::state_t state, state_next;

  // fill count and overflow flag
  logic [CW-1:0] fill_count;
  logic          overflow_seen;
  logic          in_acc;

  // ram port
  logic          we;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  // header bytes
  logic [7:0] src, dst;
  logic [3:0] kind;
  logic [3:0] fidx;
  logic [1:0] rcnt;       // bytes of current field read
  logic [15:0] acc;
  hbd_pkg::field_desc_t f;
  hbd_pkg::msg_desc_t   m;
  logic [8:0] byte_addr;
  logic [CW-1:0] plen;
  logic [1:0] nbytes;

  // classify source and type into kind
  logic [1:0] cls;
  logic [3:0] ckind;
  hbd_pkg::msg_desc_t cm;
  logic [7:0] gb;

  // header check outcome
  logic       chk_emit;
  logic       chk_fields;
  logic [1:0] chk_status;
  logic [3:0] chk_kind;

  // field read and emit control
  logic        rd_done;
  logic [23:0] fvalue;
  logic        emit_done;
  logic        emit_next;

  hbd_ram #(.Width(8), .Depth(MAX_FRAME_BYTES)) u_ram (
    .clk(clk), .we(we), .waddr(fill_count[AW-1:0]), .wdata(in_item.data_byte),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_stall = (state != hbd_pkg::S_RECV);
  assign in_acc   = in_valid && !in_stall;
  assign we       = in_acc && (fill_count < CW'(MAX_FRAME_BYTES));

  assign f = hbd_pkg::field_desc(kind, fidx);
  assign m = hbd_pkg::msg_desc(kind);
  assign nbytes = (f.kind == hbd_pkg::FkFlag || f.arg == 3'd0) ? 2'd1 :
                  (f.arg > 3'd3) ? 2'd3 : f.arg[1:0];
  assign byte_addr = 9'd3 + 9'(f.off) + 9'(rcnt);
  assign plen = fill_count - CW'(3);

  // read address per state; byte 0 is read while bytes come in and bytes 1
  // and 2 in the decode states, so each header byte is back in the next state
  always_comb begin
    raddr = '0;
    unique case (state)
      hbd_pkg::S_RECV: raddr = '0;
      hbd_pkg::S_DEC0: raddr = AW'(1);
      hbd_pkg::S_DEC1: raddr = AW'(2);
      default: raddr = byte_addr[AW-1:0];
    endcase
  end

  function automatic logic [7:0] guard(input logic [8:0] a, input logic [CW-1:0] fc,
                                        input logic [7:0] d);
    return (a < 9'(fc)) ? d : 8'd0;
  endfunction

  // rdata holds the type byte while in the check state
  always_comb begin
    cls = ClsUnhandled;
    ckind = hbd_pkg::MkFast;
    case (src)
      hbd_pkg::SrcBoiler: begin
        case (rdata)
          hbd_pkg::TyUnknown1: begin cls = ClsKnown; ckind = hbd_pkg::MkUnknown1; end
          hbd_pkg::TyFast:     begin cls = ClsKnown; ckind = hbd_pkg::MkFast; end
          hbd_pkg::TySlow:     begin cls = ClsKnown; ckind = hbd_pkg::MkSlow; end
          hbd_pkg::TyHotWater: begin cls = ClsKnown; ckind = hbd_pkg::MkHotWater; end
          default: cls = ClsUnhandled;
        endcase
      end
      hbd_pkg::SrcCtrl: begin
        case (rdata)
          hbd_pkg::TyCircuit1: begin cls = ClsKnown; ckind = hbd_pkg::MkCircuit1; end
          hbd_pkg::TyCircuit2: begin cls = ClsKnown; ckind = hbd_pkg::MkCircuit2; end
          hbd_pkg::TyOutdoor:  begin cls = ClsKnown; ckind = hbd_pkg::MkOutdoor; end
          hbd_pkg::TyNop0, hbd_pkg::TyNop1, hbd_pkg::TyNop2, hbd_pkg::TyNop3,
          hbd_pkg::TyNop4: cls = ClsNone;
          default: cls = ClsUnhandled;
        endcase
      end
      hbd_pkg::SrcSolar: begin
        if (rdata == hbd_pkg::TyWm1) begin
          cls = ClsKnown;
          ckind = hbd_pkg::MkWm1;
        end else if (rdata == hbd_pkg::TyWm2) begin
          cls = ClsKnown;
          ckind = hbd_pkg::MkWm2;
        end
      end
      hbd_pkg::SrcMixer: begin
        if (rdata == hbd_pkg::TyMixer) begin
          cls = ClsKnown;
          ckind = hbd_pkg::MkMixer;
        end
      end
      default: cls = ClsUnhandled;
    endcase
  end

  assign cm = hbd_pkg::msg_desc(ckind);
  assign gb = guard(byte_addr, fill_count, rdata);

  // frame check in priority order: overflow, polling, short, no-op,
  // unhandled, length, then field decode
  always_comb begin
    chk_emit = 1'b1;
    chk_fields = 1'b0;
    chk_status = hbd_pkg::StLength;
    chk_kind = hbd_pkg::MkFast;
    if (overflow_seen) begin
      chk_emit = 1'b1;
    end else if (fill_count >= CW'(2) && (dst & hbd_pkg::PollBit) != 8'd0) begin
      chk_emit = 1'b0;
    end else if (fill_count < CW'(3)) begin
      chk_emit = 1'b1;
    end else if (cls == ClsNone) begin
      chk_emit = 1'b0;
    end else if (cls == ClsUnhandled) begin
      chk_status = hbd_pkg::StUnhandled;
    end else if (cm.at_least ? (plen < CW'(cm.len)) : (plen != CW'(cm.len))) begin
      chk_kind = ckind;
    end else begin
      chk_emit = 1'b0;
      chk_fields = 1'b1;
    end
  end

  assign rd_done   = (2'(rcnt + 2'd1) >= nbytes);
  assign emit_done = !out_valid || (!out_stall && out_item.last_result);
  assign emit_next = out_valid && !out_stall && !out_item.last_result;

  // field value from the bytes read so far and the last one
  always_comb begin
    if (f.kind == hbd_pkg::FkFlag) begin
      fvalue = 24'(gb[f.arg]);
    end else if (nbytes == 2'd1) begin
      fvalue = (f.kind == hbd_pkg::FkNum) ? {{16{gb[7]}}, gb} : {16'd0, gb};
    end else if (nbytes == 2'd2) begin
      fvalue = (f.kind == hbd_pkg::FkNum) ? {{8{acc[7]}}, acc[7:0], gb}
                                          : {8'd0, acc[7:0], gb};
    end else begin
      fvalue = {acc[15:0], gb};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hbd_pkg::S_RECV: if (in_acc && in_item.last_byte) state_next = hbd_pkg::S_DEC0;
      hbd_pkg::S_DEC0: state_next = hbd_pkg::S_DEC1;
      hbd_pkg::S_DEC1: state_next = hbd_pkg::S_CHECK;
      hbd_pkg::S_CHECK: state_next = chk_fields ? hbd_pkg::S_RD2 : hbd_pkg::S_EMIT;
      hbd_pkg::S_RD0: state_next = hbd_pkg::S_RD1;
      hbd_pkg::S_RD1: state_next = rd_done ? hbd_pkg::S_EMIT : hbd_pkg::S_RD0;
      hbd_pkg::S_RD2: state_next = hbd_pkg::S_RD0;
      hbd_pkg::S_EMIT: begin
        if (emit_done) state_next = hbd_pkg::S_RECV;
        else if (emit_next) state_next = hbd_pkg::S_RD2;
      end
      default: state_next = hbd_pkg::S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hbd_pkg::S_RECV;
      fill_count <= '0;
      overflow_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        hbd_pkg::S_RECV: begin
          if (in_acc) begin
            if (fill_count < CW'(MAX_FRAME_BYTES)) fill_count <= fill_count + CW'(1);
            else overflow_seen <= 1'b1;
          end
        end
        hbd_pkg::S_DEC0: src <= rdata;
        hbd_pkg::S_DEC1: begin
          dst <= (fill_count >= CW'(2)) ? rdata : 8'd0;
        end
        hbd_pkg::S_CHECK: begin
          fidx <= '0;
          rcnt <= '0;
          acc  <= '0;
          kind <= ckind;
          out_item <= '{message_kind: chk_kind, field_index: '0, field_kind: '0,
                        field_value: '0, scale_code: '0, status: chk_status,
                        last_result: 1'b1};
          out_valid <= chk_emit;
        end
        hbd_pkg::S_RD0: ;
        hbd_pkg::S_RD1: begin
          acc <= {acc[7:0], gb};
          rcnt <= rcnt + 2'd1;
          if (rd_done) begin
            out_item <= '{message_kind: kind, field_index: fidx, field_kind: f.kind,
                          field_value: fvalue, scale_code: f.scale,
                          status: hbd_pkg::StField,
                          last_result: (5'(fidx) + 5'd1 == m.count)};
            out_valid <= 1'b1;
          end
        end
        hbd_pkg::S_RD2: ;
        hbd_pkg::S_EMIT: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          if (emit_done) begin
            fill_count <= '0;
            overflow_seen <= 1'b0;
          end
          if (emit_next) begin
            fidx <= fidx + 4'd1;
            rcnt <= '0;
            acc <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `HBD_ASSERT_NEVER(a_no_input_busy, clk, rst, in_acc && in_stall, "input while busy")
  `HBD_ASSERT_IMPL(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "result dropped")
  `HBD_ASSERT_NEVER(a_fill_range, clk, rst, fill_count > CW'(MAX_FRAME_BYTES), "fill overflow")

endmodule
